### rtl/rmcf_pkg.sv
`timescale 1ns / 1ps
package rmcf_pkg;

  localparam int MaxWidth  = 2048;
  localparam int MaxRadius = 2;
  localparam int RingLines = 2 * MaxRadius + 1;
  localparam int WinCoeffs = RingLines * RingLines;
  localparam int ColAw     = $clog2(MaxWidth);
  localparam int RamDepth  = RingLines * MaxWidth;
  localparam int RamAw     = $clog2(RamDepth);
  localparam int PixW      = 24;
  localparam int SumW      = 22;
  localparam int QuoW      = 20;
  localparam int CfgIdxW   = 4;
  localparam int CfgDataW  = 64;

  typedef enum logic [CfgIdxW-1:0] {
    RegMaskSize   = 4'd0,
    RegDivisor    = 4'd1,
    RegFrameWidth = 4'd2,
    RegFrameHeight= 4'd3,
    RegCoeffBank0 = 4'd4,
    RegCoeffBank1 = 4'd5,
    RegCoeffBank2 = 4'd6,
    RegCoeffBank3 = 4'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BkIdle,
    BkRead,
    BkLast,
    BkSetup,
    BkDiv,
    BkDone
  } bk_state_e;

  typedef struct packed {
    logic [2:0]                 mask_size;
    logic [11:0]                divisor;
    logic [11:0]                frame_width;
    logic [12:0]                frame_height;
    logic [WinCoeffs-1:0][7:0]  coeff;
  } cfg_t;

  // one output position handed from front to back
  typedef struct packed {
    logic        pass;
    logic [2:0]  ring;
    logic [11:0] col;
    logic        frame_end;
  } job_t;

  typedef struct packed {
    logic busy;
    logic out_full;
  } bk_status_t;

  function automatic logic [2:0] ring_inc(input logic [2:0] ring);
    ring_inc = (ring == 3'(RingLines - 1)) ? 3'd0 : ring + 3'd1;
  endfunction

  function automatic logic [2:0] ring_mod(input logic [3:0] v);
    logic [3:0] t;
    t = v;
    if (t >= 4'(2 * RingLines)) begin
      t = t - 4'(2 * RingLines);
    end else if (t >= 4'(RingLines)) begin
      t = t - 4'(RingLines);
    end
    ring_mod = t[2:0];
  endfunction

  function automatic logic [1:0] radius(input logic [2:0] mask_size);
    radius = (mask_size == 3'd5) ? 2'd2 : 2'd1;
  endfunction

endpackage

### rtl/rmcf_if.sv
`timescale 1ns / 1ps
interface pix_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  modport source (output valid, req_type, in_red, in_green, in_blue, input ready);
  modport sink (input valid, req_type, in_red, in_green, in_blue, output ready);
endinterface

interface pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_end;
  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

interface cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rmcf_pkg::CfgIdxW-1:0]  index;
  logic [rmcf_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/rmcf_ram.sv
`timescale 1ns / 1ps
module rmcf_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

### rtl/rmcf_queue.sv
`timescale 1ns / 1ps
module rmcf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rmcf_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output rmcf_pkg::job_t job_o
);
  rmcf_pkg::job_t slot_q [2];
  logic           wp_q, rp_q, wp_d, rp_d;
  logic [1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = slot_q[rp_q];

  // pointer and fill count update
  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = ~wp_q;
    end
    if (pop_i) begin
      rp_d = ~rp_q;
    end
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= job_i;
    end
  end
endmodule

### rtl/rmcf_front.sv
`timescale 1ns / 1ps
module rmcf_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rmcf_pkg::cfg_t               cfg_i,
  pix_in_if.sink                       in_i,
  input  logic                         q_full_i,
  input  logic                         bk_busy_i,
  output logic                         push_o,
  output rmcf_pkg::job_t               job_o,
  output logic                         wr_en_o,
  output logic [rmcf_pkg::RamAw-1:0]   wr_addr_o,
  output logic [rmcf_pkg::PixW-1:0]    wr_data_o
);
  logic [1:0]  rad;
  logic [11:0] wid;
  logic [12:0] hgt;
  logic [11:0] rad12;
  logic [12:0] rad13;

  // input raster position, one row beyond the frame plus the drain
  logic [11:0] col_q, col_d, col0, col1;
  logic [13:0] row_q, row_d, row0;
  logic [2:0]  ring_q, ring_d, ring0;
  // output raster position
  logic [11:0] oc_q, oc_d, oc0;
  logic [12:0] orow_q, orow_d, orow0;
  logic [2:0]  oring_q, oring_d, oring0;

  logic        xfer, flush, at_zero, in_frame, emit, over, fend;

  // effective geometry
  always_comb begin
    rad   = rmcf_pkg::radius(cfg_i.mask_size);
    rad12 = {10'd0, rad};
    rad13 = {11'd0, rad};
    if (cfg_i.frame_width < 12'd8) begin
      wid = 12'd8;
    end else if (cfg_i.frame_width > 12'(rmcf_pkg::MaxWidth)) begin
      wid = 12'(rmcf_pkg::MaxWidth);
    end else begin
      wid = cfg_i.frame_width;
    end
    hgt = (cfg_i.frame_height < 13'd8) ? 13'd8 : cfg_i.frame_height;
  end

  // a new frame starts only once the back end has finished reading the old one
  assign in_i.ready = !q_full_i && !(at_zero && bk_busy_i);
  assign xfer       = in_i.valid && in_i.ready;
  assign flush      = in_i.req_type;

  // classify the item
  always_comb begin
    col0  = (col_q >= wid) ? 12'd0 : col_q;
    row0  = (col_q >= wid) ? row_q + 14'd1 : row_q;
    ring0 = (col_q >= wid) ? rmcf_pkg::ring_inc(ring_q) : ring_q;
    oc0    = (oc_q >= wid) ? 12'd0 : oc_q;
    orow0  = (oc_q >= wid) ? orow_q + 13'd1 : orow_q;
    oring0 = (oc_q >= wid) ? rmcf_pkg::ring_inc(oring_q) : oring_q;
    col1   = col0 + 12'd1;

    at_zero  = (row0 == 14'd0) && (col0 == 12'd0);
    in_frame = (row0 < {1'b0, hgt});
    emit     = (row0 > {12'd0, rad}) || ((row0 == {12'd0, rad}) && (col0 >= rad12));
    over     = (row0 > ({1'b0, hgt} + {12'd0, rad})) ||
               ((row0 == ({1'b0, hgt} + {12'd0, rad})) && (col0 >= rad12));
    fend     = (orow0 == hgt - 13'd1) && (oc0 == wid - 12'd1);

    job_o.pass      = (oc0 < rad12) || (oc0 >= wid - rad12) ||
                      (orow0 < rad13) || (orow0 >= hgt - rad13);
    job_o.ring      = oring0;
    job_o.col       = oc0;
    job_o.frame_end = fend;
  end

  // counter advance and line store write
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    ring_d  = ring_q;
    oc_d    = oc_q;
    orow_d  = orow_q;
    oring_d = oring_q;
    push_o  = 1'b0;
    wr_en_o = 1'b0;
    if (xfer && !(at_zero && flush)) begin
      if (over) begin
        col_d   = '0;
        row_d   = '0;
        ring_d  = '0;
        oc_d    = '0;
        orow_d  = '0;
        oring_d = '0;
      end else begin
        wr_en_o = in_frame;
        if (col1 >= wid) begin
          col_d  = 12'd0;
          row_d  = row0 + 14'd1;
          ring_d = rmcf_pkg::ring_inc(ring0);
        end else begin
          col_d  = col1;
          row_d  = row0;
          ring_d = ring0;
        end
        if (emit) begin
          push_o = 1'b1;
          if (oc0 + 12'd1 >= wid) begin
            oc_d    = 12'd0;
            orow_d  = orow0 + 13'd1;
            oring_d = rmcf_pkg::ring_inc(oring0);
          end else begin
            oc_d    = oc0 + 12'd1;
            orow_d  = orow0;
            oring_d = oring0;
          end
          if (fend) begin
            col_d   = '0;
            row_d   = '0;
            ring_d  = '0;
            oc_d    = '0;
            orow_d  = '0;
            oring_d = '0;
          end
        end
      end
    end
  end

  assign wr_addr_o = {ring0, col0[rmcf_pkg::ColAw-1:0]};
  assign wr_data_o = {in_i.in_red, in_i.in_green, in_i.in_blue};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      ring_q  <= '0;
      oc_q    <= '0;
      orow_q  <= '0;
      oring_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      ring_q  <= ring_d;
      oc_q    <= oc_d;
      orow_q  <= orow_d;
      oring_q <= oring_d;
    end
  end
endmodule

### rtl/rmcf_back.sv
`timescale 1ns / 1ps
module rmcf_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rmcf_pkg::cfg_t               cfg_i,
  input  logic                         job_valid_i,
  input  rmcf_pkg::job_t               job_i,
  output logic                         pop_o,
  output logic                         rd_en_o,
  output logic [rmcf_pkg::RamAw-1:0]   rd_addr_o,
  input  logic [rmcf_pkg::PixW-1:0]    rd_data_i,
  output rmcf_pkg::bk_status_t         status_o,
  pix_out_if.source                    out_o
);
  rmcf_pkg::bk_state_e state_q, state_d;
  rmcf_pkg::job_t      job_q;

  logic [1:0]  rad;
  logic [2:0]  side;
  logic [2:0]  l_q, k_q;
  logic [4:0]  cidx_q, aidx_q;
  logic        acc_en_q;
  logic        last_issue;
  logic [2:0]  rd_ring;
  logic [11:0] rd_col;
  logic [11:0] dvs;
  logic [4:0]  step_q;
  logic        can_out;

  logic signed [rmcf_pkg::SumW-1:0] acc_q [3];
  logic [rmcf_pkg::QuoW-1:0]        num_q [3];
  logic [11:0]                      rem_q [3];
  logic                             neg_q [3];
  logic [7:0]                       res_q [3];
  logic [7:0]                       lane_px [3];
  logic [12:0]                      trial [3];

  logic       ov_q;
  logic [7:0] or_q, og_q, ob_q;
  logic       ofe_q;

  assign rad     = rmcf_pkg::radius(cfg_i.mask_size);
  assign side    = (rad == 2'd2) ? 3'd5 : 3'd3;
  assign dvs     = (cfg_i.divisor == 12'd0) ? 12'd1 : cfg_i.divisor;
  assign can_out = !ov_q || out_o.ready;
  assign last_issue = (l_q == side - 3'd1) && (k_q == side - 3'd1);

  assign lane_px[0] = rd_data_i[23:16];
  assign lane_px[1] = rd_data_i[15:8];
  assign lane_px[2] = rd_data_i[7:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rmcf_pkg::BkIdle:  if (job_valid_i) state_d = rmcf_pkg::BkRead;
      rmcf_pkg::BkRead:  if (job_q.pass || last_issue) state_d = rmcf_pkg::BkLast;
      rmcf_pkg::BkLast:  state_d = job_q.pass ? rmcf_pkg::BkDone : rmcf_pkg::BkSetup;
      rmcf_pkg::BkSetup: state_d = rmcf_pkg::BkDiv;
      rmcf_pkg::BkDiv:   if (step_q == 5'(rmcf_pkg::QuoW - 1)) state_d = rmcf_pkg::BkDone;
      rmcf_pkg::BkDone:  if (can_out) state_d = rmcf_pkg::BkIdle;
      default:           state_d = rmcf_pkg::BkIdle;
    endcase
  end

  // window read address, the pass case reads the center pixel only
  always_comb begin
    if (job_q.pass) begin
      rd_ring = job_q.ring;
      rd_col  = job_q.col;
    end else begin
      rd_ring = rmcf_pkg::ring_mod({1'b0, job_q.ring} + 4'(rmcf_pkg::RingLines)
                                   - {2'd0, rad} + {1'b0, l_q});
      rd_col  = job_q.col - {10'd0, rad} + {9'd0, k_q};
    end
  end

  // outputs of the control
  always_comb begin
    pop_o     = (state_q == rmcf_pkg::BkIdle) && job_valid_i;
    rd_en_o   = (state_q == rmcf_pkg::BkRead);
    rd_addr_o = {rd_ring, rd_col[rmcf_pkg::ColAw-1:0]};
    status_o.busy     = (state_q != rmcf_pkg::BkIdle);
    status_o.out_full = ov_q;
  end

  // restoring divide step per channel
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trial[i] = {rem_q[i], num_q[i][rmcf_pkg::QuoW-1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rmcf_pkg::BkIdle;
      acc_en_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      acc_en_q <= (state_q == rmcf_pkg::BkRead) && !job_q.pass;
      if (state_q == rmcf_pkg::BkDone && can_out) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    aidx_q <= cidx_q;
    case (state_q)
      rmcf_pkg::BkIdle: begin
        job_q  <= job_i;
        l_q    <= '0;
        k_q    <= '0;
        cidx_q <= '0;
        for (int i = 0; i < 3; i++) begin
          acc_q[i] <= '0;
        end
      end
      rmcf_pkg::BkRead: begin
        cidx_q <= cidx_q + 5'd1;
        if (k_q == side - 3'd1) begin
          k_q <= '0;
          l_q <= l_q + 3'd1;
        end else begin
          k_q <= k_q + 3'd1;
        end
      end
      rmcf_pkg::BkLast: begin
        if (job_q.pass) begin
          for (int i = 0; i < 3; i++) begin
            res_q[i] <= lane_px[i];
          end
        end
      end
      rmcf_pkg::BkSetup: begin
        step_q <= '0;
        for (int i = 0; i < 3; i++) begin
          neg_q[i] <= acc_q[i][rmcf_pkg::SumW-1];
          num_q[i] <= acc_q[i][rmcf_pkg::QuoW-1:0];
          rem_q[i] <= '0;
        end
      end
      rmcf_pkg::BkDiv: begin
        step_q <= step_q + 5'd1;
        for (int i = 0; i < 3; i++) begin
          if (trial[i] >= {1'b0, dvs}) begin
            rem_q[i] <= 12'(trial[i] - {1'b0, dvs});
            num_q[i] <= {num_q[i][rmcf_pkg::QuoW-2:0], 1'b1};
          end else begin
            rem_q[i] <= trial[i][11:0];
            num_q[i] <= {num_q[i][rmcf_pkg::QuoW-2:0], 1'b0};
          end
        end
      end
      rmcf_pkg::BkDone: begin
        if (can_out) begin
          ofe_q <= job_q.frame_end;
          if (job_q.pass) begin
            or_q <= res_q[0];
            og_q <= res_q[1];
            ob_q <= res_q[2];
          end else begin
            or_q <= neg_q[0] ? 8'd0 : (num_q[0] > 20'd255) ? 8'd255 : num_q[0][7:0];
            og_q <= neg_q[1] ? 8'd0 : (num_q[1] > 20'd255) ? 8'd255 : num_q[1][7:0];
            ob_q <= neg_q[2] ? 8'd0 : (num_q[2] > 20'd255) ? 8'd255 : num_q[2][7:0];
          end
        end
      end
      default: begin
      end
    endcase
    // multiply-accumulate on the registered read data
    if (acc_en_q) begin
      for (int i = 0; i < 3; i++) begin
        acc_q[i] <= acc_q[i] + rmcf_pkg::SumW'($signed({1'b0, lane_px[i]}) *
                                              $signed(cfg_i.coeff[aidx_q]));
      end
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.out_red   = or_q;
  assign out_o.out_green = og_q;
  assign out_o.out_blue  = ob_q;
  assign out_o.frame_end = ofe_q;
endmodule

### rtl/rgb_mask_convolution_filter_top.sv
`timescale 1ns / 1ps
// rgb 3x3 / 5x5 convolution filter with divisor: pixels enter in raster order and each
// accepted item gives the filtered pixel radius lines plus radius pixels behind it, pixels
// within radius of a frame edge pass through unchanged, and radius*width+radius flush items
// after a frame push out its last rows. The front end takes one item per cycle into a
// two-entry position queue while the queue has room; the back end works one position at a
// time, an edge pixel reading only its center and a filtered pixel walking the whole window
// through the single read port of the line store and then the 20-step divider. Output
// back-pressure adds its stall cycles, and the first item of a frame waits until the back
// end has emptied the queue and finished the previous frame's last position.
module rgb_mask_convolution_filter_top (
  input logic       clk_i,
  input logic       rst_ni,
  pix_in_if.sink    in_i,
  pix_out_if.source out_o,
  cfg_if.sink       cfg_i
);
  rmcf_pkg::cfg_t       cfg_q;
  rmcf_pkg::job_t       push_job, q_job;
  rmcf_pkg::bk_status_t bk_status;
  logic                 push, q_full, q_valid, pop, bk_busy;
  logic                 wr_en, rd_en;
  logic [rmcf_pkg::RamAw-1:0] wr_addr, rd_addr;
  logic [rmcf_pkg::PixW-1:0]  wr_data, rd_data;

  assign cfg_i.ready = 1'b1;
  assign bk_busy     = q_valid || bk_status.busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mask_size    <= 3'd3;
      cfg_q.divisor      <= 12'd1;
      cfg_q.frame_width  <= 12'd640;
      cfg_q.frame_height <= 13'd480;
      cfg_q.coeff        <= '0;
    end else if (cfg_i.valid) begin
      case (rmcf_pkg::cfg_reg_e'(cfg_i.index))
        rmcf_pkg::RegMaskSize:    cfg_q.mask_size    <= cfg_i.data[2:0];
        rmcf_pkg::RegDivisor:     cfg_q.divisor      <= cfg_i.data[11:0];
        rmcf_pkg::RegFrameWidth:  cfg_q.frame_width  <= cfg_i.data[11:0];
        rmcf_pkg::RegFrameHeight: cfg_q.frame_height <= cfg_i.data[12:0];
        rmcf_pkg::RegCoeffBank0: begin
          for (int i = 0; i < 8; i++) cfg_q.coeff[i] <= cfg_i.data[8*i +: 8];
        end
        rmcf_pkg::RegCoeffBank1: begin
          for (int i = 0; i < 8; i++) cfg_q.coeff[8 + i] <= cfg_i.data[8*i +: 8];
        end
        rmcf_pkg::RegCoeffBank2: begin
          for (int i = 0; i < 8; i++) cfg_q.coeff[16 + i] <= cfg_i.data[8*i +: 8];
        end
        rmcf_pkg::RegCoeffBank3:  cfg_q.coeff[24] <= cfg_i.data[7:0];
        default: begin
        end
      endcase
    end
  end

  rmcf_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_i      (in_i),
    .q_full_i  (q_full),
    .bk_busy_i (bk_busy),
    .push_o    (push),
    .job_o     (push_job),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data)
  );

  rmcf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  rmcf_ram #(
    .Width (rmcf_pkg::PixW),
    .Depth (rmcf_pkg::RamDepth)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  rmcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .pop_o       (pop),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .status_o    (bk_status),
    .out_o       (out_o)
  );

  // queue never takes a position while full
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_full)
    else $error("position queue overflow");

  // an idle back end picks up a waiting position at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!bk_status.busy && q_valid) |=> bk_status.busy)
    else $error("back end did not start on a queued position");

  // a pop only happens with a position present
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> q_valid)
    else $error("pop from empty position queue");
endmodule
